// ----- rtl/dsa_pkg.sv -----
// Shared types and constants for the descriptor slot allocator.
// Used by dsa_alu, dsa_stack and descriptor_slot_allocator; depends on nothing.
package dsa_pkg;

   localparam int unsigned SLOT_CAPACITY_DEF = 1024;
   localparam int unsigned ADDR_W            = 64;
   localparam int unsigned STRIDE_W          = 13;
   localparam int unsigned LIMIT_W           = 11;
   localparam int unsigned SLOT_INDEX_W      = 10;
   localparam int unsigned STRIDE_IDX_W      = $clog2(STRIDE_W);
   localparam int unsigned CSR_INDEX_W       = 2;

   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(1024);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CPU_BASE = 2'd0,
      CSR_GPU_BASE = 2'd1,
      CSR_STRIDE   = 2'd2,
      CSR_LIMIT    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

endpackage

// ----- rtl/descriptor_slot_allocator.sv -----
// Descriptor slot allocator top level: sequencer, configuration registers and result register.
// Depends on dsa_pkg, dsa_alu and dsa_stack.
//
//   port group | direction | flow control   | carries
//   req_*      | in        | valid / stall  | func, release_address
//   rsp_*      | out       | valid / stall  | status, cpu/gpu address, slot index
//   csr_*      | in        | valid / ready  | register index, 64-bit data
//
// An allocate pops the free stack first when it holds a slot, then multiplies and adds
// both bases; a free subtracts the CPU base, multiplies, compares, divides and pushes.
// Both use the shared adder: 13 shift-add steps over the stride bits, then, for a free,
// one restoring division step per index bit. Refused items finish early. Reset is
// synchronous and empties the stack. req_stall is high while an item is in work; a
// stalled result holds the sequencer in its last state, so the next request waits.
module descriptor_slot_allocator
   import dsa_pkg::*;
#(
   parameter int unsigned SLOT_CAPACITY = SLOT_CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   input  logic [ADDR_W-1:0]       req_release_address,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [ADDR_W-1:0]       rsp_cpu_address,
   output logic [ADDR_W-1:0]       rsp_gpu_address,
   output logic [SLOT_INDEX_W-1:0] rsp_slot_index,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [ADDR_W-1:0]       csr_data
);

   localparam int unsigned IDX_W  = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
   localparam int unsigned CNT_W  = $clog2(SLOT_CAPACITY + 1);
   localparam int unsigned SH_W   = CNT_W + STRIDE_W;
   localparam int unsigned UL_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int unsigned STEP_W = ($clog2(IDX_W) > STRIDE_IDX_W) ? $clog2(IDX_W)
                                                                   : STRIDE_IDX_W;

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_POP     = 10'b00_0000_0010,
      S_MUL     = 10'b00_0000_0100,
      S_ADD_CPU = 10'b00_0000_1000,
      S_ADD_GPU = 10'b00_0001_0000,
      S_SUB     = 10'b00_0010_0000,
      S_CMP     = 10'b00_0100_0000,
      S_DIV     = 10'b00_1000_0000,
      S_PUSH    = 10'b01_0000_0000,
      S_FINISH  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]   cpu_base_ff, gpu_base_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [LIMIT_W-1:0]  limit_ff;

   logic                func_ff, func_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   acc_ff, acc_in;
   logic [SH_W-1:0]     shift_ff, shift_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   status_type          status_ff, status_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    bump_ff, bump_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]       rsp_cpu_ff, rsp_cpu_in;
   logic [ADDR_W-1:0]       rsp_gpu_ff, rsp_gpu_in;
   logic [SLOT_INDEX_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic [ADDR_W-1:0] alu_a, alu_b, alu_res;
   logic              alu_sub, alu_carry;

   logic              st_wr_en, st_rd_en;
   logic [IDX_W-1:0]  st_wr_addr, st_rd_addr, st_rd_data;
   logic [CNT_W-1:0]  count_m1;

   logic [UL_W-1:0]   limit_ext, cap_ext;
   logic [CNT_W-1:0]  usable;
   logic              req_take, rsp_free;

   assign limit_ext = UL_W'(limit_ff);
   assign cap_ext   = UL_W'(SLOT_CAPACITY);
   assign usable    = (limit_ext < cap_ext) ? CNT_W'(limit_ext) : CNT_W'(cap_ext);
   assign count_m1  = count_ff - CNT_W'(1);

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   dsa_alu u_alu (
      .opa    (alu_a),
      .opb    (alu_b),
      .sub    (alu_sub),
      .result (alu_res),
      .carry  (alu_carry)
   );

   dsa_stack #(
      .DEPTH  (SLOT_CAPACITY),
      .ADDR_B (IDX_W),
      .DATA_B (IDX_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (idx_ff),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   assign st_rd_addr = count_m1[IDX_W-1:0];
   assign st_wr_addr = count_ff[IDX_W-1:0];

   // Operand selection for the shared adder.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_MUL: begin
            alu_a = acc_ff;
            alu_b = stride_ff[step_ff[STRIDE_IDX_W-1:0]] ? ADDR_W'(shift_ff) : '0;
         end
         S_ADD_CPU: begin
            alu_a = cpu_base_ff;
            alu_b = acc_ff;
         end
         S_ADD_GPU: begin
            alu_a = gpu_base_ff;
            alu_b = acc_ff;
         end
         S_SUB: begin
            alu_a   = addr_ff;
            alu_b   = cpu_base_ff;
            alu_sub = 1'b1;
         end
         S_CMP: begin
            alu_a   = addr_ff;
            alu_b   = acc_ff;
            alu_sub = 1'b1;
         end
         S_DIV: begin
            alu_a   = acc_ff;
            alu_b   = ADDR_W'(shift_ff);
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      addr_in   = addr_ff;
      acc_in    = acc_ff;
      shift_in  = shift_ff;
      step_in   = step_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      count_in  = count_ff;
      bump_in   = bump_ff;
      st_wr_en  = 1'b0;
      st_rd_en  = 1'b0;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_cpu_in    = rsp_cpu_ff;
      rsp_gpu_in    = rsp_gpu_ff;
      rsp_slot_in   = rsp_slot_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               func_in   = req_func;
               addr_in   = req_release_address;
               acc_in    = '0;
               step_in   = '0;
               status_in = ST_OK;
               if (req_func == FUNC_FREE) begin
                  if (stride_ff == '0) begin
                     status_in = ST_RANGE;
                     state_in  = S_FINISH;
                  end else begin
                     state_in = S_SUB;
                  end
               end else if (count_ff != '0) begin
                  st_rd_en = 1'b1;
                  count_in = count_m1;
                  state_in = S_POP;
               end else if (bump_ff < usable) begin
                  idx_in   = bump_ff[IDX_W-1:0];
                  shift_in = SH_W'(bump_ff);
                  bump_in  = bump_ff + CNT_W'(1);
                  state_in = S_MUL;
               end else begin
                  status_in = ST_FULL;
                  state_in  = S_FINISH;
               end
            end
         end
         S_POP: begin
            idx_in   = st_rd_data;
            shift_in = SH_W'(st_rd_data);
            state_in = S_MUL;
         end
         S_MUL: begin
            // Shift-add multiply by the stride, one stride bit per cycle.
            acc_in   = alu_res;
            shift_in = shift_ff << 1;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STRIDE_W - 1)) begin
               step_in  = '0;
               state_in = (func_ff == FUNC_FREE) ? S_CMP : S_ADD_CPU;
            end
         end
         S_ADD_CPU: begin
            addr_in  = alu_res;
            state_in = S_ADD_GPU;
         end
         S_ADD_GPU: begin
            acc_in   = (gpu_base_ff == '0) ? '0 : alu_res;
            state_in = S_FINISH;
         end
         S_SUB: begin
            if (!alu_carry) begin
               status_in = ST_RANGE;
               state_in  = S_FINISH;
            end else begin
               addr_in  = alu_res;
               shift_in = SH_W'(usable);
               state_in = S_MUL;
            end
         end
         S_CMP: begin
            // The offset must lie below usable slots times the stride.
            if (alu_carry) begin
               status_in = ST_RANGE;
               state_in  = S_FINISH;
            end else begin
               acc_in   = addr_ff;
               shift_in = SH_W'(stride_ff) << (IDX_W - 1);
               idx_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // Restoring division: the quotient is known to fit in the index width.
            if (alu_carry) begin
               acc_in = alu_res;
            end
            idx_in   = (idx_ff << 1) | IDX_W'(alu_carry);
            shift_in = shift_ff >> 1;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(IDX_W - 1)) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (count_ff == CNT_W'(SLOT_CAPACITY)) begin
               status_in = ST_OVERFLOW;
            end else begin
               st_wr_en = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (status_ff == ST_OK && func_ff == FUNC_ALLOC) begin
                  rsp_cpu_in = addr_ff;
                  rsp_gpu_in = acc_ff;
               end else begin
                  rsp_cpu_in = '0;
                  rsp_gpu_in = '0;
               end
               if (status_ff == ST_FULL || status_ff == ST_RANGE) begin
                  rsp_slot_in = '0;
               end else begin
                  rsp_slot_in = SLOT_INDEX_W'(idx_ff);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cpu_base_ff  <= '0;
         gpu_base_ff  <= '0;
         stride_ff    <= STRIDE_RESET;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bump_ff      <= bump_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CPU_BASE: cpu_base_ff <= csr_data;
               CSR_GPU_BASE: gpu_base_ff <= csr_data;
               CSR_STRIDE:   stride_ff   <= csr_data[STRIDE_W-1:0];
               CSR_LIMIT:    limit_ff    <= csr_data[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      addr_ff       <= addr_in;
      acc_ff        <= acc_in;
      shift_ff      <= shift_in;
      step_ff       <= step_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cpu_ff    <= rsp_cpu_in;
      rsp_gpu_ff    <= rsp_gpu_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_cpu_address = rsp_cpu_ff;
   assign rsp_gpu_address = rsp_gpu_ff;
   assign rsp_slot_index  = rsp_slot_ff;

endmodule

// ----- rtl/dsa_alu.sv -----
// Shared 64-bit add/subtract unit with carry out for the slot allocator.
// Depends on dsa_pkg for the address width.
module dsa_alu
   import dsa_pkg::*;
(
   input  logic [ADDR_W-1:0] opa,
   input  logic [ADDR_W-1:0] opb,
   input  logic              sub,
   output logic [ADDR_W-1:0] result,
   output logic              carry
);

   logic [ADDR_W:0]   sum_w;
   logic [ADDR_W-1:0] opb_w;

   // On subtraction a set carry means opa is not below opb.
   assign opb_w  = sub ? ~opb : opb;
   assign sum_w  = {1'b0, opa} + {1'b0, opb_w} + {{ADDR_W{1'b0}}, sub};
   assign result = sum_w[ADDR_W-1:0];
   assign carry  = sum_w[ADDR_W];

endmodule

// ----- rtl/dsa_stack.sv -----
// Free-slot stack storage: one write port and one registered read port.
// Depends on dsa_pkg for the default depth.
module dsa_stack
   import dsa_pkg::*;
#(
   parameter int unsigned DEPTH  = SLOT_CAPACITY_DEF,
   parameter int unsigned ADDR_B = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int unsigned DATA_B = ADDR_B
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_B-1:0] wr_addr,
   input  logic [DATA_B-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_B-1:0] rd_addr,
   output logic [DATA_B-1:0] rd_data
);

   logic [DATA_B-1:0] stack_ff [0:DEPTH-1];
   logic [DATA_B-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= stack_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- test/descriptor_slot_allocator_tb.sv -----
// Self-checking testbench for descriptor_slot_allocator: allocate and free transfers
// checked against a cycle-free prediction of the slot stack and bump counter.
// Depends on dsa_pkg and the descriptor_slot_allocator RTL.
module descriptor_slot_allocator_tb;
   import dsa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES   = 60;

   typedef struct {
      logic              func;
      logic [ADDR_W-1:0] address;
   } slot_request_type;

   typedef struct {
      status_type              status;
      logic [ADDR_W-1:0]       cpu;
      logic [ADDR_W-1:0]       gpu;
      logic [SLOT_INDEX_W-1:0] slot;
   } slot_outcome_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_func = FUNC_ALLOC;
   logic [ADDR_W-1:0]       req_release_address = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_status;
   logic [ADDR_W-1:0]       rsp_cpu_address;
   logic [ADDR_W-1:0]       rsp_gpu_address;
   logic [SLOT_INDEX_W-1:0] rsp_slot_index;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   csr_index_type           csr_index = CSR_CPU_BASE;
   logic [ADDR_W-1:0]       csr_data = '0;

   // Mirror of the allocator's configuration and slot bookkeeping.
   logic [ADDR_W-1:0]       cfg_cpu_base = '0;
   logic [ADDR_W-1:0]       cfg_gpu_base = '0;
   logic [STRIDE_W-1:0]     cfg_stride = STRIDE_RESET;
   logic [LIMIT_W-1:0]      cfg_limit = LIMIT_RESET;
   logic [SLOT_INDEX_W-1:0] free_slot_stack [SLOT_CAPACITY_DEF];
   int unsigned             free_slot_depth = 0;
   int unsigned             bump_next = 0;

   slot_request_type        requests_pending [$];
   slot_outcome_type        slot_outcomes_due [$];
   bit                      request_held = 1'b0;
   int unsigned             gap_left = 0;
   int unsigned             stall_left = 0;
   int unsigned             quiet_left [2] = '{0, 0};
   int unsigned             quiet_cycles = 0;
   int unsigned             mismatch_count = 0;

   descriptor_slot_allocator dut (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic int unsigned usable_slots();
      return (int'(cfg_limit) < SLOT_CAPACITY_DEF) ? int'(cfg_limit) : SLOT_CAPACITY_DEF;
   endfunction

   // An address inside the given slot, at a random byte within it.
   function automatic logic [ADDR_W-1:0] slot_address(input int unsigned idx);
      logic [ADDR_W-1:0] byte_offset;
      byte_offset = (cfg_stride > 1) ? ADDR_W'($urandom_range(0, int'(cfg_stride) - 1))
                                     : '0;
      return cfg_cpu_base + ADDR_W'(idx) * ADDR_W'(cfg_stride) + byte_offset;
   endfunction

   // Side 0 is the request sender, side 1 the result receiver. Now and then a
   // side runs a stretch of transfers with no waiting at all.
   function automatic int unsigned draw_wait(input int side);
      if (quiet_left[side] > 0) begin
         quiet_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet_left[side] = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic slot_outcome_type predict_slot_outcome(input logic func,
                                                             input logic [ADDR_W-1:0] address);
      slot_outcome_type        outcome;
      logic [SLOT_INDEX_W-1:0] idx;
      logic [ADDR_W-1:0]       offset;
      logic [ADDR_W-1:0]       quotient;
      bit                      granted;
      outcome.status = ST_OK;
      outcome.cpu = '0;
      outcome.gpu = '0;
      outcome.slot = '0;
      idx = '0;
      granted = 1'b1;
      if (func == FUNC_ALLOC) begin
         if (free_slot_depth > 0) begin
            free_slot_depth--;
            idx = free_slot_stack[free_slot_depth];
         end else if (bump_next < usable_slots()) begin
            idx = SLOT_INDEX_W'(bump_next);
            bump_next++;
         end else begin
            outcome.status = ST_FULL;
            granted = 1'b0;
         end
         if (granted) begin
            offset = ADDR_W'(idx) * ADDR_W'(cfg_stride);
            outcome.cpu = cfg_cpu_base + offset;
            outcome.gpu = (cfg_gpu_base != '0) ? cfg_gpu_base + offset : '0;
            outcome.slot = idx;
         end
      end else if (cfg_stride == '0 || address < cfg_cpu_base) begin
         outcome.status = ST_RANGE;
      end else begin
         quotient = (address - cfg_cpu_base) / ADDR_W'(cfg_stride);
         if (quotient >= ADDR_W'(usable_slots())) begin
            outcome.status = ST_RANGE;
         end else begin
            outcome.slot = quotient[SLOT_INDEX_W-1:0];
            // A full stack reports the index but keeps nothing.
            if (free_slot_depth >= SLOT_CAPACITY_DEF) begin
               outcome.status = ST_OVERFLOW;
            end else begin
               free_slot_stack[free_slot_depth] = quotient[SLOT_INDEX_W-1:0];
               free_slot_depth++;
            end
         end
      end
      return outcome;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: %s", $time, what);
   endtask

   task automatic push_request(input logic func, input logic [ADDR_W-1:0] address);
      slot_request_type item;
      item.func = func;
      item.address = address;
      requests_pending.insert(requests_pending.size(), item);
   endtask

   task automatic wait_idle();
      while (requests_pending.size() != 0 || request_held || slot_outcomes_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [ADDR_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CPU_BASE: cfg_cpu_base = data;
         CSR_GPU_BASE: cfg_gpu_base = data;
         CSR_STRIDE:   cfg_stride = data[STRIDE_W-1:0];
         CSR_LIMIT:    cfg_limit = data[LIMIT_W-1:0];
         default:      ;
      endcase
   endtask

   // Request driver: the prediction is taken at the edge where the transfer completes.
   always @(posedge clock) begin
      slot_request_type item;
      if (reset) begin
         req_valid <= 1'b0;
         request_held = 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            slot_outcomes_due.insert(slot_outcomes_due.size(),
                                     predict_slot_outcome(req_func, req_release_address));
            request_held = 1'b0;
         end
         if (!request_held) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (requests_pending.size() != 0) begin
               item = requests_pending.pop_front();
               req_valid <= 1'b1;
               req_func <= item.func;
               req_release_address <= item.address;
               request_held = 1'b1;
               gap_left = draw_wait(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: the stall pattern runs whether or not a result is offered.
   always @(posedge clock) begin
      slot_outcome_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (slot_outcomes_due.size() == 0) begin
               report_mismatch($sformatf("result with no request outstanding, status %0d",
                                         rsp_status));
            end else begin
               want = slot_outcomes_due.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %s",
                                            rsp_status, want.status.name()));
               if (rsp_cpu_address !== want.cpu)
                  report_mismatch($sformatf("cpu address %h, expected %h",
                                            rsp_cpu_address, want.cpu));
               if (rsp_gpu_address !== want.gpu)
                  report_mismatch($sformatf("gpu address %h, expected %h",
                                            rsp_gpu_address, want.gpu));
               if (rsp_slot_index !== want.slot)
                  report_mismatch($sformatf("slot index %0d, expected %0d",
                                            rsp_slot_index, want.slot));
            end
            stall_left = draw_wait(1);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int unsigned free_pct;
      int unsigned usable;
      int unsigned kind;
      int unsigned idx;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: bump allocation, a double free through an unaligned
      // address, pops in last-in order, and frees outside the heap.
      push_request(FUNC_ALLOC, '0);
      push_request(FUNC_ALLOC, '1);
      push_request(FUNC_ALLOC, '0);
      push_request(FUNC_FREE, 64'd32);
      push_request(FUNC_FREE, 64'd63);
      push_request(FUNC_ALLOC, '0);
      push_request(FUNC_ALLOC, '0);
      push_request(FUNC_ALLOC, '0);
      push_request(FUNC_FREE, 64'd32768);
      push_request(FUNC_FREE, '1);
      wait_idle();

      // Widest stride and limit field, GPU base that wraps on every slot.
      write_csr(CSR_CPU_BASE, 64'h8000_0000_0000_1000);
      write_csr(CSR_GPU_BASE, '1);
      write_csr(CSR_STRIDE, ADDR_W'({STRIDE_W{1'b1}}));
      write_csr(CSR_LIMIT, ADDR_W'({LIMIT_W{1'b1}}));
      push_request(FUNC_FREE, 64'h8000_0000_0000_0FFF);
      push_request(FUNC_ALLOC, '0);
      push_request(FUNC_FREE, slot_address(SLOT_CAPACITY_DEF - 1));
      push_request(FUNC_ALLOC, '0);
      push_request(FUNC_FREE, slot_address(SLOT_CAPACITY_DEF));
      push_request(FUNC_FREE, '0);
      wait_idle();

      // Zero stride: an allocation lands on the base itself, a free is refused.
      write_csr(CSR_STRIDE, '0);
      write_csr(CSR_CPU_BASE, '1);
      push_request(FUNC_ALLOC, '0);
      push_request(FUNC_FREE, '1);
      wait_idle();

      write_csr(CSR_CPU_BASE, '0);
      write_csr(CSR_GPU_BASE, '0);
      write_csr(CSR_STRIDE, 64'd1);
      write_csr(CSR_LIMIT, 64'd8);
      push_request(FUNC_FREE, 64'd7);
      push_request(FUNC_FREE, 64'd6);
      wait_idle();

      // With the limit cut to zero, stacked slots still come back before the
      // heap reports full.
      write_csr(CSR_LIMIT, '0);
      push_request(FUNC_ALLOC, '0);
      push_request(FUNC_ALLOC, '0);
      push_request(FUNC_ALLOC, '0);
      push_request(FUNC_FREE, '0);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 3))
            0:       write_csr(CSR_CPU_BASE, '0);
            1:       write_csr(CSR_CPU_BASE, '1 - ADDR_W'($urandom_range(0, 1 << 20)));
            2:       write_csr(CSR_CPU_BASE, {$urandom, $urandom});
            default: write_csr(CSR_CPU_BASE, {32'h0, $urandom});
         endcase
         case ($urandom_range(0, 3))
            0:       write_csr(CSR_GPU_BASE, '0);
            1:       write_csr(CSR_GPU_BASE, '1);
            default: write_csr(CSR_GPU_BASE, {$urandom, $urandom});
         endcase
         case ($urandom_range(0, 6))
            0:       write_csr(CSR_STRIDE, 64'd1);
            1:       write_csr(CSR_STRIDE, ADDR_W'({STRIDE_W{1'b1}}));
            2:       write_csr(CSR_STRIDE, 64'd4096);
            3:       write_csr(CSR_STRIDE, ADDR_W'(1) << $urandom_range(0, STRIDE_W - 1));
            4:       write_csr(CSR_STRIDE, '0);
            default: write_csr(CSR_STRIDE, ADDR_W'($urandom_range(1, 4096)));
         endcase
         case ($urandom_range(0, 5))
            0:       write_csr(CSR_LIMIT, ADDR_W'($urandom_range(0, 4)));
            1:       write_csr(CSR_LIMIT, 64'd1024);
            2:       write_csr(CSR_LIMIT, ADDR_W'({LIMIT_W{1'b1}}));
            3:       write_csr(CSR_LIMIT, 64'd1023);
            default: write_csr(CSR_LIMIT, ADDR_W'($urandom_range(0, 2047)));
         endcase
         free_pct = $urandom_range(25, 75);
         usable = usable_slots();
         for (int i = 0; i < 125; i++) begin
            if ($urandom_range(0, 99) >= free_pct) begin
               push_request(FUNC_ALLOC, {$urandom, $urandom});
            end else begin
               // Mostly frees of slots inside the heap; the rest miss it.
               kind = $urandom_range(0, 11);
               idx = (usable == 0) ? $urandom_range(0, 15) : $urandom_range(0, usable - 1);
               case (kind)
                  8:       push_request(FUNC_FREE, slot_address(usable + $urandom_range(0, 3)));
                  9:       push_request(FUNC_FREE, {$urandom, $urandom});
                  10:      push_request(FUNC_FREE,
                                        cfg_cpu_base - ADDR_W'($urandom_range(1, 64)));
                  default: push_request(FUNC_FREE, slot_address(idx));
               endcase
            end
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (slot_outcomes_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", slot_outcomes_due.size()));
      end
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
